>>> hdl/aof_pkg.sv
`default_nettype none

package aof_pkg;

  localparam int PIX_W         = 32;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 13;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 13;
  localparam int ALPHA_LSB     = 24;

  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT    = 13'd4096;
  localparam logic [PIX_W-1:0]        OUTLINE_WHITE = 32'hFFFF_FFFF;
  localparam logic [7:0]              ALPHA_MASK    = 8'hFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Position info of one pixel, worked out at the input.
  typedef struct packed {
    logic col_zero;
    logic r0;    // current row inside the image
    logic r1;    // row above inside the image
    logic r2;    // row two above inside the image
    logic emit;
    logic last;
  } aof_pos_t;

  function automatic logic alpha_clear(input logic [PIX_W-1:0] p);
    return (p[ALPHA_LSB +: 8] & ALPHA_MASK) == 8'h00;
  endfunction

  function automatic logic is_neighbour(input logic [PIX_W-1:0] p);
    return !alpha_clear(p) && (p != OUTLINE_WHITE);
  endfunction

endpackage

`default_nettype wire

>>> hdl/aof_ram.sv
`default_nettype none

module aof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/aof_window.sv
`default_nettype none

module aof_window import aof_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire aof_pos_t         pos,
  input  wire logic [PIX_W-1:0] pix,
  input  wire logic [PIX_W-1:0] mid,
  input  wire logic [PIX_W-1:0] top,
  output logic      [PIX_W-1:0] center_out
);

  logic [8:0]       window_flags;
  logic [8:0]       window_flags_next;
  logic [PIX_W-1:0] center_pixel;
  logic [2:0]       newcol;
  logic             outline;

  assign newcol = {pos.r0 && is_neighbour(pix),
                   pos.r1 && is_neighbour(mid),
                   pos.r2 && is_neighbour(top)};

  always_comb begin
    if (pos.col_zero) begin
      // right neighbour column of the finished row lies outside the image
      window_flags_next = {newcol, 6'b000000};
      outline           = alpha_clear(center_pixel) && (window_flags[8:3] != 6'b000000);
    end else begin
      window_flags_next = {newcol, window_flags[8:3]};
      outline           = alpha_clear(center_pixel) && (window_flags_next != 9'b000000000);
    end
  end

  assign center_out = outline ? OUTLINE_WHITE : center_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_flags <= '0;
      center_pixel <= '0;
    end else if (adv) begin
      window_flags <= window_flags_next;
      center_pixel <= mid;
    end
  end

endmodule

`default_nettype wire

>>> hdl/alpha_outline_3x3_filter.sv
// An accepted transaction waits in s1 and then loads the output register if it emits;
// its result is the pixel that entered w_eff+1 transactions earlier.
// Throughput: one transaction per cycle if not stalled, set by one read per line store.
// Reset clears the counters, window flags, pipeline and output valid; the line stores
// are not cleared, since no stale entry read before the frame writes it reaches an output.
`default_nettype none

module alpha_outline_3x3_filter import aof_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,    // pixel_in
  input  wire logic [0:0]            s_tuser,    // pad
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [PIX_W-1:0]      m_tdata,    // pixel_out
  output logic                       m_tlast     // last_pixel
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WIDTH_REG_W > MWB) ? WIDTH_REG_W : MWB;
  localparam int RW  = HEIGHT_REG_W + 1;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [EW-1:0]           w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [RW-1:0]           h_plus1;

  logic [WIDTH_REG_W-1:0]  col_cnt, col_cnt_next;
  logic [HEIGHT_REG_W-1:0] row_cnt, row_cnt_next;
  logic [WIDTH_REG_W-1:0]  col;
  logic [HEIGHT_REG_W-1:0] row;
  logic [RW-1:0]           row_x;
  logic                    restart;
  logic [AW-1:0]           idx;
  aof_pos_t                pos;

  logic                    accept;
  logic                    out_free;
  logic                    s1_adv;
  logic                    s1_valid;
  aof_pos_t                s1_pos;
  logic [PIX_W-1:0]        s1_pix;
  logic [AW-1:0]           s1_idx;
  logic                    fwd_valid;
  logic [PIX_W-1:0]        fwd_data;

  logic [PIX_W-1:0]        upper_rd;
  logic [PIX_W-1:0]        middle_rd;
  logic [PIX_W-1:0]        top_pix;
  logic [PIX_W-1:0]        center_out;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1);
      image_height <= HEIGHT_REG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_wr_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_wr_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (image_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end
  end

  assign h_plus1 = {1'b0, h_eff} + RW'(1);

  // position of the incoming pixel
  assign restart = (EW'(col_cnt) >= w_eff) || ({1'b0, row_cnt} > h_plus1);
  assign col     = restart ? '0 : col_cnt;
  assign row     = restart ? '0 : row_cnt;
  assign row_x   = {1'b0, row};
  assign idx     = AW'(col);

  always_comb begin
    pos.col_zero = (col == '0);
    pos.r0       = (row < h_eff);
    pos.r1       = (row != '0) && (row <= h_eff);
    pos.r2       = (row >= HEIGHT_REG_W'(2)) && (row_x <= h_plus1);
    pos.emit     = pos.col_zero ? pos.r2 : pos.r1;
    pos.last     = pos.col_zero && pos.r2 && (row_x == h_plus1);
  end

  always_comb begin
    if (pos.last) begin
      col_cnt_next = '0;
      row_cnt_next = '0;
    end else if ((EW'(col) + EW'(1)) >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = row + HEIGHT_REG_W'(1);
    end else begin
      col_cnt_next = col + WIDTH_REG_W'(1);
      row_cnt_next = row;
    end
  end

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt   <= col_cnt_next;
        row_cnt   <= row_cnt_next;
        // upper store write of the previous pixel lands in this same cycle
        fwd_valid <= s1_adv && (s1_idx == idx);
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_pos.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos;
      s1_pix   <= s_tdata;
      s1_idx   <= idx;
      fwd_data <= middle_rd;
    end
    if (s1_adv && s1_pos.emit) begin
      m_tdata <= center_out;
      m_tlast <= s1_pos.last;
    end
  end

  aof_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx),
    .wr_data (middle_rd),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (upper_rd)
  );

  aof_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_row (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (idx),
    .wr_data (s_tdata),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (middle_rd)
  );

  assign top_pix = fwd_valid ? fwd_data : upper_rd;

  aof_window u_window (
    .clk        (clk),
    .rst        (rst),
    .adv        (s1_adv),
    .pos        (s1_pos),
    .pix        (s1_pix),
    .mid        (middle_rd),
    .top        (top_pix),
    .center_out (center_out)
  );

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (EW'(col_cnt) < $past(w_eff)))
    else $error("column count left the row");

  a_last_at_row_start: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pos.last) |-> (s1_pos.col_zero && s1_pos.emit))
    else $error("frame end flagged away from a row start");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pos.emit && m_tvalid && !m_tready) |=> s1_valid)
    else $error("pending result dropped while output stalled");

endmodule

`default_nettype wire
